// ===== hw/rtl/tkms_pkg.sv =====
package tkms_pkg;

  localparam int unsigned TopKDefault = 5;
  localparam int unsigned LikesW      = 16;
  localparam int unsigned IdW         = 16;

  typedef struct packed {
    logic [LikesW-1:0] likes;
    logic [IdW-1:0]    id;
  } entry_t;

  // True when candidate a ranks strictly above kept entry b.
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic res;
    if (a.likes != b.likes) begin
      res = (a.likes > b.likes);
    end else begin
      res = (a.id < b.id);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/top_k_most_liked_selector.sv =====
// An item accepted into the input register is merged into the ranked list when it
// advances; on a query's last item the snapshot loads at that same edge and offers the first result.
// Throughput: one item per cycle via the parallel compare-and-shift row, unless a last item stalls.
// A query end emits up to TOP_K results from a snapshot buffer, one per cycle while
// out_stall_i is low; a further last item waits in the input register till the buffer drains.
// Reset (rst_ni low, asynchronous) empties the ranked list, input register and snapshot buffer.
module top_k_most_liked_selector #(
  parameter int unsigned TOP_K = tkms_pkg::TopKDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        first_item_i,
  input  logic                        last_item_i,
  input  logic [tkms_pkg::LikesW-1:0] like_count_i,
  input  logic [tkms_pkg::IdW-1:0]    item_id_i,
  input  logic                        already_liked_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tkms_pkg::LikesW-1:0] ranked_likes_o,
  output logic [tkms_pkg::IdW-1:0]    ranked_id_o,
  output logic                        list_empty_o,
  output logic                        final_result_o
);

  // input register
  logic                 in_valid_q;
  logic                 first_q, last_q, liked_q;
  tkms_pkg::entry_t     cand_q;

  // ranked list
  tkms_pkg::entry_t     kept_q [TOP_K];
  tkms_pkg::entry_t     kept_d [TOP_K];
  logic [TOP_K-1:0]     kept_vld_q, kept_vld_d;

  // emission snapshot
  tkms_pkg::entry_t     snap_q [TOP_K];
  logic [TOP_K-1:0]     snap_vld_q;
  logic                 snap_empty_q;

  logic                 out_take;
  logic                 snap_free;
  logic                 advance;
  logic                 load_snap;
  logic [TOP_K-1:0]     snap_vld_next;
  logic [TOP_K-1:0]     base_vld, base_vld_prev, above, above_prev;
  tkms_pkg::entry_t     base_prev [TOP_K];
  logic                 qualify;

  assign out_valid_o = snap_vld_q[0] | snap_empty_q;
  assign out_take    = out_valid_o & ~out_stall_i;
  assign snap_vld_next = snap_vld_q >> 1;

  // Buffer is free when idle or when its final transaction completes now.
  assign snap_free = ~out_valid_o | (out_take & (snap_empty_q | ~snap_vld_next[0]));
  assign advance   = in_valid_q & (~last_q | snap_free);
  assign in_stall_o = in_valid_q & ~advance;
  assign load_snap = advance & last_q;

  assign ranked_likes_o = snap_empty_q ? '0 : snap_q[0].likes;
  assign ranked_id_o    = snap_empty_q ? '0 : snap_q[0].id;
  assign list_empty_o   = snap_empty_q;
  assign final_result_o = snap_empty_q | ~snap_vld_next[0];

  // Compare-and-shift row: every cell compares against the candidate at once.
  always_comb begin
    base_vld = first_q ? '0 : kept_vld_q;
    qualify  = (cand_q.likes != '0) & ~liked_q;
    for (int i = 0; i < TOP_K; i++) begin
      above[i] = ~base_vld[i] | tkms_pkg::ranks_above(cand_q, kept_q[i]);
    end
    above_prev    = above << 1;
    base_vld_prev = base_vld << 1;
    base_prev[0]  = cand_q;
    for (int i = 1; i < TOP_K; i++) begin
      base_prev[i] = kept_q[i-1];
    end
    for (int i = 0; i < TOP_K; i++) begin
      if (qualify && above[i]) begin
        kept_d[i]     = above_prev[i] ? base_prev[i] : cand_q;
        kept_vld_d[i] = above_prev[i] ? base_vld_prev[i] : 1'b1;
      end else begin
        kept_d[i]     = kept_q[i];
        kept_vld_d[i] = base_vld[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      first_q      <= first_item_i;
      last_q       <= last_item_i;
      liked_q      <= already_liked_i;
      cand_q.likes <= like_count_i;
      cand_q.id    <= item_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_vld_q <= '0;
    end else if (advance) begin
      kept_vld_q <= kept_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kept_q <= kept_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q   <= '0;
      snap_empty_q <= 1'b0;
    end else if (load_snap) begin
      snap_vld_q   <= kept_vld_d;
      snap_empty_q <= ~kept_vld_d[0];
    end else if (out_take) begin
      // drop the delivered entry and advance the rest
      snap_vld_q   <= snap_empty_q ? snap_vld_q : snap_vld_next;
      snap_empty_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_snap) begin
      snap_q <= kept_d;
    end else if (out_take) begin
      for (int i = 0; i < TOP_K - 1; i++) begin
        snap_q[i] <= snap_q[i+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_kept_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((kept_vld_q >> 1) & ~kept_vld_q) == '0)
    else $error("ranked list has a hole");

  a_snap_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((snap_vld_q >> 1) & ~snap_vld_q) == '0)
    else $error("snapshot has a hole");

  a_empty_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_empty_q |-> (snap_vld_q == '0))
    else $error("empty marker with entries pending");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && last_q && out_valid_o))
    else $error("input stalled without a pending query end");

  a_snap_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_snap |=> out_valid_o)
    else $error("query end produced no result");
`endif

endmodule
